// File: design/scc_pkg.sv
package scc_pkg;

  localparam int SAMPLE_BITS = 12;

  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);
  localparam int QCW = $clog2(QDEPTH + 1);

  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_OWN_ID = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BROADCAST_ID = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_VERSION_WORD = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_HB_INTERVAL = CFG_IDX_W'(3);

  localparam logic [10:0] OWN_ID_RST = 11'h107;
  localparam logic [10:0] BROADCAST_ID_RST = 11'h7DF;
  localparam logic [31:0] VERSION_RST = 32'd1003;
  localparam logic [31:0] HB_INTERVAL_RST = 32'd10000;

  localparam logic [7:0] CMD_VERSION = 8'd1;
  localparam logic [7:0] CMD_REALTIME = 8'd2;
  localparam logic [7:0] CMD_BUFFERED = 8'd3;
  localparam logic [7:0] CMD_STOP = 8'd4;
  localparam logic [7:0] CMD_STATUS = 8'd5;
  localparam logic [7:0] CMD_SET_SIZE = 8'd6;

  localparam logic [7:0] BCAST_HDR0 = 8'h05;
  localparam logic [7:0] BCAST_HDR1 = 8'h12;
  localparam logic [7:0] REPLY_LEN = 8'h08;
  localparam logic [7:0] HB_MARK = 8'h7F;

  localparam logic [31:0] BUF_LIMIT = 32'd32768;
  localparam logic [15:0] BUF_DEFAULT = 16'd8192;

  typedef enum logic [1:0] {
    KIND_BROADCAST = 2'd0,
    KIND_REPLY     = 2'd1,
    KIND_HEARTBEAT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    MODE_STOPPED  = 2'd0,
    MODE_REALTIME = 2'd1,
    MODE_BUFFERED = 2'd2
  } mode_t;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_CMD  = 1'b1
  } op_t;

  typedef struct packed {
    logic [10:0] own_id;
    logic [10:0] broadcast_id;
    logic [31:0] version_word;
    logic [31:0] hb_interval;
  } cfg_t;

  typedef struct packed {
    op_t                   op;
    logic [SAMPLE_BITS-1:0] sample_a;
    logic [SAMPLE_BITS-1:0] sample_b;
    logic [7:0]            command;
    logic [15:0]           reply_id;
    logic [15:0]           size;
  } item_t;

endpackage

// File: design/scc_front.sv
module scc_front import scc_pkg::*; (
  input  logic                   in_push,
  input  logic                   in_action,
  input  logic                   in_sample_ok,
  input  logic [SAMPLE_BITS-1:0] in_sample_a,
  input  logic [SAMPLE_BITS-1:0] in_sample_b,
  input  logic [10:0]            in_frame_id,
  input  logic [7:0]             in_command,
  input  logic [15:0]            in_reply_id,
  input  logic [31:0]            in_argument,
  input  cfg_t                   cfg,
  input  logic                   q_full,
  output logic                   q_push,
  output item_t                  q_item
);

  logic keep;

  // drop failed ticks and foreign frames here; they touch no state
  always_comb begin
    if (in_action == 1'b0) begin
      keep = in_sample_ok;
    end else begin
      keep = (in_frame_id == cfg.own_id);
    end
  end

  assign q_push = in_push && !q_full && keep;

  always_comb begin
    q_item.op = (in_action == 1'b1) ? OP_CMD : OP_TICK;
    q_item.sample_a = in_sample_a;
    q_item.sample_b = in_sample_b;
    q_item.command = in_command;
    q_item.reply_id = in_reply_id;
    // clamp the requested buffer size up front
    if (in_argument == 32'd0 || in_argument > BUF_LIMIT) begin
      q_item.size = BUF_DEFAULT;
    end else begin
      q_item.size = in_argument[15:0];
    end
  end

endmodule

// File: design/scc_queue.sv
module scc_queue import scc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  take,
  output logic  valid,
  output item_t head_item
);

  item_t           slot_r [QDEPTH];
  logic [QAW-1:0]  wr_ptr_r;
  logic [QAW-1:0]  rd_ptr_r;
  logic [QCW-1:0]  count_r;
  logic [QAW-1:0]  wr_ptr_nxt;
  logic [QAW-1:0]  rd_ptr_nxt;
  logic [QCW-1:0]  count_nxt;
  logic            do_take;

  assign full = (count_r == QCW'(QDEPTH));
  assign valid = (count_r != '0);
  assign head_item = slot_r[rd_ptr_r];
  assign do_take = take && valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QAW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_take ? rd_ptr_r + QAW'(1) : rd_ptr_r;
    count_nxt = count_r;
    if (push && !do_take) begin
      count_nxt = count_r + QCW'(1);
    end else if (!push && do_take) begin
      count_nxt = count_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: design/scc_back.sv
module scc_back import scc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_take,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [1:0]  out_frame_kind,
  output logic [15:0] out_dest_id,
  output logic [63:0] out_payload
);

  mode_t        mode_r, mode_nxt;
  logic [31:0]  tick_r, tick_nxt;
  logic [31:0]  due_r, due_nxt;
  logic [15:0]  size_r, size_nxt;
  logic         res_valid_r, res_valid_nxt;
  kind_t        kind_r;
  logic [15:0]  dest_r;
  logic [63:0]  payload_r;

  logic         take;
  logic         emit;
  kind_t        emit_kind;
  logic [15:0]  emit_dest;
  logic [63:0]  emit_payload;
  logic [31:0]  tick_inc;
  logic [31:0]  due_base;
  logic [31:0]  due_rearm;
  logic         hb_fire;
  logic [31:0]  reply_val;
  logic         known;
  logic [23:0]  reply_head;

  // advance only when the result register is free or drains this cycle
  assign take = q_valid && (!res_valid_r || out_pop);
  assign q_take = take;

  assign tick_inc = tick_r + 32'd1;
  assign due_base = (q_item.op == OP_TICK) ? tick_inc : tick_r;
  assign due_rearm = due_base + cfg.hb_interval;
  assign hb_fire = (mode_r == MODE_STOPPED) && (tick_inc > due_r);
  assign reply_head = {REPLY_LEN, 5'd0, cfg.own_id};

  // next state
  always_comb begin
    mode_nxt = mode_r;
    tick_nxt = tick_r;
    due_nxt = due_r;
    size_nxt = size_r;
    if (take) begin
      if (q_item.op == OP_TICK) begin
        tick_nxt = tick_inc;
        if (hb_fire) begin
          due_nxt = due_rearm;
        end
      end else begin
        due_nxt = due_rearm;
        case (q_item.command)
          CMD_REALTIME: mode_nxt = MODE_REALTIME;
          CMD_BUFFERED: mode_nxt = MODE_BUFFERED;
          CMD_STOP:     mode_nxt = MODE_STOPPED;
          CMD_SET_SIZE: size_nxt = q_item.size;
          default:      mode_nxt = mode_r;
        endcase
      end
    end
  end

  // result of the item at the queue head
  always_comb begin
    known = 1'b1;
    case (q_item.command)
      CMD_VERSION:  reply_val = cfg.version_word;
      CMD_REALTIME: reply_val = 32'(MODE_REALTIME);
      CMD_BUFFERED: reply_val = 32'(MODE_BUFFERED);
      CMD_STOP:     reply_val = 32'(MODE_STOPPED);
      CMD_STATUS:   reply_val = 32'(mode_r);
      CMD_SET_SIZE: reply_val = 32'(q_item.size);
      default: begin
        reply_val = 32'd0;
        known = 1'b0;
      end
    endcase

    emit = 1'b0;
    emit_kind = KIND_REPLY;
    emit_dest = q_item.reply_id;
    emit_payload = {reply_head, q_item.command, reply_val};
    if (q_item.op == OP_TICK) begin
      emit_dest = 16'(cfg.broadcast_id);
      if (mode_r == MODE_REALTIME) begin
        emit = 1'b1;
        emit_kind = KIND_BROADCAST;
        emit_payload = {BCAST_HDR0, BCAST_HDR1, 16'(q_item.sample_a),
                        16'(q_item.sample_b), 16'd0};
      end else if (hb_fire) begin
        emit = 1'b1;
        emit_kind = KIND_HEARTBEAT;
        emit_payload = {reply_head, HB_MARK, tick_inc};
      end
    end else begin
      emit = known;
    end
  end

  always_comb begin
    res_valid_nxt = res_valid_r;
    if (take && emit) begin
      res_valid_nxt = 1'b1;
    end else if (out_pop) begin
      res_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_STOPPED;
      tick_r <= '0;
      due_r <= '0;
      size_r <= BUF_DEFAULT;
      res_valid_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      tick_r <= tick_nxt;
      due_r <= due_nxt;
      size_r <= size_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      kind_r <= emit_kind;
      dest_r <= emit_dest;
      payload_r <= emit_payload;
    end
  end

  assign out_empty = !res_valid_r;
  assign out_frame_kind = kind_r;
  assign out_dest_id = dest_r;
  assign out_payload = payload_r;

endmodule

// File: design/sensor_can_command_responder_core.sv
// Sensor command responder.
// Input channel: a queue write port (in_push / in_full). Each item is either a
// sample tick (in_action low) or a received command frame (in_action high).
// Result channel: a queue read port (out_empty / out_pop) carrying frame kind,
// destination id and eight payload bytes, byte 0 in the top bits.
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; always
// ready. Write it only while no item is in flight.
// An accepted item is written into the 4-entry item queue, and the execute step
// then writes its result into the result register that drives the out_ ports.
// Throughput: one item per cycle while the result register is free or popped;
// failed ticks and frames for other ids are dropped on entry and take no queue slot.
// When the receiver stalls, the one-entry result register holds its frame,
// execution pauses, the item queue fills and in_full rises after four more
// items. Reset clears the queue, the result register, the stream mode,
// counters and configuration to their defaults; the first good tick after
// reset produces a heartbeat in stopped mode if no command came before it.
module sensor_can_command_responder_core import scc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  output logic                   in_full,
  input  logic                   in_action,
  input  logic                   in_sample_ok,
  input  logic [SAMPLE_BITS-1:0] in_sample_a,
  input  logic [SAMPLE_BITS-1:0] in_sample_b,
  input  logic [10:0]            in_frame_id,
  input  logic [7:0]             in_command,
  input  logic [15:0]            in_reply_id,
  input  logic [31:0]            in_argument,
  output logic                   out_empty,
  input  logic                   out_pop,
  output logic [1:0]             out_frame_kind,
  output logic [15:0]            out_dest_id,
  output logic [63:0]            out_payload,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]            cfg_data
);

  cfg_t  cfg_r, cfg_nxt;
  logic  q_push;
  logic  q_full;
  logic  q_valid;
  logic  q_take;
  item_t q_in_item;
  item_t q_head_item;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_OWN_ID:       cfg_nxt.own_id = cfg_data[10:0];
        REG_BROADCAST_ID: cfg_nxt.broadcast_id = cfg_data[10:0];
        REG_VERSION_WORD: cfg_nxt.version_word = cfg_data;
        REG_HB_INTERVAL:  cfg_nxt.hb_interval = cfg_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_id <= OWN_ID_RST;
      cfg_r.broadcast_id <= BROADCAST_ID_RST;
      cfg_r.version_word <= VERSION_RST;
      cfg_r.hb_interval <= HB_INTERVAL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_full = q_full;

  scc_front u_front (
    .in_push      (in_push),
    .in_action    (in_action),
    .in_sample_ok (in_sample_ok),
    .in_sample_a  (in_sample_a),
    .in_sample_b  (in_sample_b),
    .in_frame_id  (in_frame_id),
    .in_command   (in_command),
    .in_reply_id  (in_reply_id),
    .in_argument  (in_argument),
    .cfg          (cfg_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (q_in_item)
  );

  scc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .take      (q_take),
    .valid     (q_valid),
    .head_item (q_head_item)
  );

  scc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_valid        (q_valid),
    .q_item         (q_head_item),
    .q_take         (q_take),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_frame_kind (out_frame_kind),
    .out_dest_id    (out_dest_id),
    .out_payload    (out_payload)
  );

endmodule

// File: design/scc_checker.sv
module scc_checker import scc_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_push,
  input logic                   in_full,
  input logic                   in_action,
  input logic                   in_sample_ok,
  input logic [SAMPLE_BITS-1:0] in_sample_a,
  input logic [SAMPLE_BITS-1:0] in_sample_b,
  input logic [10:0]            in_frame_id,
  input logic [7:0]             in_command,
  input logic [15:0]            in_reply_id,
  input logic [31:0]            in_argument,
  input logic                   out_empty,
  input logic                   out_pop,
  input logic [1:0]             out_frame_kind,
  input logic [15:0]            out_dest_id,
  input logic [63:0]            out_payload,
  input logic                   cfg_valid,
  input logic                   cfg_ready,
  input logic [CFG_IDX_W-1:0]   cfg_index,
  input logic [31:0]            cfg_data
);

  // reset drains the result side
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result shown right after reset");

  // a waiting item holds until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_payload) &&
      $stable(out_dest_id) && $stable(out_frame_kind)))
    else $error("waiting result changed or vanished");

  a_broadcast_form: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_frame_kind == KIND_BROADCAST) |->
      (out_payload[63:48] == {BCAST_HDR0, BCAST_HDR1} &&
       out_payload[15:0] == 16'd0 && out_dest_id[15:11] == 5'd0))
    else $error("malformed sample broadcast");

  a_heartbeat_form: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_frame_kind == KIND_HEARTBEAT) |->
      (out_payload[63:56] == REPLY_LEN && out_payload[39:32] == HB_MARK &&
       out_dest_id[15:11] == 5'd0))
    else $error("malformed heartbeat");

  a_kind_known: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_frame_kind == KIND_BROADCAST ||
      out_frame_kind == KIND_REPLY || out_frame_kind == KIND_HEARTBEAT))
    else $error("bad frame kind");

endmodule

bind sensor_can_command_responder_core scc_checker u_scc_checker (.*);
